// ===== sv/umrf_pkg.sv =====
`timescale 1ns / 1ps
// Shared definitions for the memory request framer: link tags, status codes,
// parameter defaults and the entry type that passes through the request queue.
// No dependencies.
package umrf_pkg;

  // Link bytes are fixed at eight bits: three tag bits over a five bit field.
  localparam int LINK_BYTE_BITS = 8;
  localparam int TAG_W          = 3;
  localparam int ID_W           = LINK_BYTE_BITS - TAG_W;
  localparam int COUNT_W        = 8;

  localparam int PAYLOAD_STORE_BITS_DEF = 72;
  localparam int QUEUE_DEPTH_DEF        = 4;

  localparam logic [TAG_W-1:0] TAG_HEAD    = 3'b100;
  localparam logic [TAG_W-1:0] TAG_CHANNEL = 3'b101;
  localparam logic [TAG_W-1:0] TAG_LENGTH  = 3'b110;
  localparam logic [TAG_W-1:0] TAG_END     = 3'b111;

  localparam logic KIND_RX = 1'b0;
  localparam logic KIND_TX = 1'b1;

  localparam logic [2:0] ST_BUSY        = 3'd0;
  localparam logic [2:0] ST_READ        = 3'd1;
  localparam logic [2:0] ST_WRITE       = 3'd2;
  localparam logic [2:0] ST_IGNORED     = 3'd3;
  localparam logic [2:0] ST_CORRUPT     = 3'd4;
  localparam logic [2:0] ST_ID_MISMATCH = 3'd5;

  // One classified item: a receive status, or a reply word to be framed.
  typedef struct packed {
    logic            kind;
    logic [2:0]      status;
    logic            seq_gap;
    logic [31:0]     mem_addr;
    logic [31:0]     write_data;
    logic [7:0]      byte_mask;
    logic [ID_W-1:0] tx_id;
    logic [31:0]     reply_word;
  } entry_t;

endpackage

// ===== sv/umrf_front.sv =====
`timescale 1ns / 1ps
// Front end: receive deframer and transmit id keeper. Classifies each accepted
// item into one queue entry. Depends on umrf_pkg.
module umrf_front #(
  parameter int PAYLOAD_STORE_BITS = umrf_pkg::PAYLOAD_STORE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_cmd,
  input  logic [7:0]           in_rx_byte,
  input  logic [31:0]          in_reply_word,
  output logic                 push_valid,
  input  logic                 push_stall,
  output umrf_pkg::entry_t     push_entry
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CHANNEL,
    PH_LENGTH,
    PH_DATA,
    PH_END
  } phase_t;

  localparam int PSB = PAYLOAD_STORE_BITS;
  localparam int IW  = umrf_pkg::ID_W;
  localparam int CW  = umrf_pkg::COUNT_W;

  phase_t                phase_r, phase_nxt;
  logic [PSB-1:0]        payload_r, payload_nxt;
  logic [CW-1:0]         bit_count_r, bit_count_nxt;
  logic [CW-1:0]         bit_target_r, bit_target_nxt;
  logic [IW-1:0]         last_rx_id_r, last_rx_id_nxt;
  logic [IW-1:0]         tx_id_r, tx_id_nxt;

  logic                  accept;
  logic [2:0]            tag;
  logic [IW-1:0]         id;
  logic [IW-1:0]         expect_id;
  logic [CW-1:0]         remaining;
  logic [2:0]            take_n;
  logic [6:0]            keep;
  logic [6:0]            new_bits;
  logic [PSB-1:0]        insert;
  logic [CW-1:0]         count_sum;
  umrf_pkg::entry_t      ent;

  assign push_valid = in_valid;
  assign in_stall   = push_stall;
  assign accept     = in_valid && !push_stall;
  assign push_entry = ent;

  assign tag       = in_rx_byte[7:5];
  assign id        = in_rx_byte[IW-1:0];
  assign expect_id = last_rx_id_r + IW'(1);

  // Up to seven payload bits per data byte, fewer on the closing chunk.
  assign remaining = bit_target_r - bit_count_r;
  assign take_n    = (remaining > CW'(7)) ? 3'd7 : remaining[2:0];

  always_comb begin
    for (int i = 0; i < 7; i++) begin
      keep[i] = (3'(i) < take_n);
    end
  end

  assign new_bits  = in_rx_byte[6:0] & keep;
  // Bits that land past the store fall off the top of the shift.
  assign insert    = {{(PSB-7){1'b0}}, new_bits} << bit_count_r;
  assign count_sum = bit_count_r + {{(CW-3){1'b0}}, take_n};

  always_comb begin
    phase_nxt      = phase_r;
    payload_nxt    = payload_r;
    bit_count_nxt  = bit_count_r;
    bit_target_nxt = bit_target_r;
    last_rx_id_nxt = last_rx_id_r;
    tx_id_nxt      = tx_id_r;
    ent            = '0;
    ent.kind       = umrf_pkg::KIND_RX;
    ent.status     = umrf_pkg::ST_BUSY;

    if (in_cmd) begin
      ent.kind       = umrf_pkg::KIND_TX;
      ent.tx_id      = tx_id_r;
      ent.reply_word = in_reply_word;
      tx_id_nxt      = tx_id_r + IW'(1);
    end else begin
      case (phase_r)
        PH_IDLE: begin
          payload_nxt = '0;
          if (tag == umrf_pkg::TAG_HEAD) begin
            bit_count_nxt  = '0;
            bit_target_nxt = '0;
            phase_nxt      = PH_CHANNEL;
            ent.seq_gap    = (id != expect_id);
          end else begin
            ent.status = umrf_pkg::ST_CORRUPT;
          end
        end
        PH_CHANNEL: begin
          if (tag == umrf_pkg::TAG_CHANNEL) begin
            phase_nxt = PH_LENGTH;
          end else begin
            phase_nxt  = PH_IDLE;
            ent.status = umrf_pkg::ST_CORRUPT;
          end
        end
        PH_LENGTH: begin
          if (tag == umrf_pkg::TAG_LENGTH) begin
            bit_target_nxt = {id, 3'b000};
            phase_nxt      = PH_DATA;
          end else begin
            phase_nxt  = PH_IDLE;
            ent.status = umrf_pkg::ST_CORRUPT;
          end
        end
        PH_DATA: begin
          if (!in_rx_byte[7]) begin
            payload_nxt   = payload_r | insert;
            bit_count_nxt = count_sum;
            if (count_sum == bit_target_r) begin
              phase_nxt = PH_END;
            end
          end else begin
            phase_nxt  = PH_IDLE;
            ent.status = umrf_pkg::ST_CORRUPT;
          end
        end
        PH_END: begin
          phase_nxt = PH_IDLE;
          if (tag != umrf_pkg::TAG_END) begin
            ent.status = umrf_pkg::ST_CORRUPT;
          end else if (id != expect_id) begin
            ent.status = umrf_pkg::ST_ID_MISMATCH;
          end else begin
            last_rx_id_nxt = id;
            if (bit_count_r == CW'(40) && payload_r[39:32] == 8'd0) begin
              ent.status   = umrf_pkg::ST_READ;
              ent.mem_addr = payload_r[31:0];
            end else if (bit_count_r == CW'(72)) begin
              ent.status     = umrf_pkg::ST_WRITE;
              ent.mem_addr   = payload_r[63:32];
              ent.write_data = payload_r[31:0];
              ent.byte_mask  = payload_r[71:64];
            end else begin
              ent.status = umrf_pkg::ST_IGNORED;
            end
          end
        end
        default: begin
          phase_nxt  = PH_IDLE;
          ent.status = umrf_pkg::ST_CORRUPT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_count_r  <= '0;
      bit_target_r <= '0;
      last_rx_id_r <= '0;
      tx_id_r      <= '0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      bit_count_r  <= bit_count_nxt;
      bit_target_r <= bit_target_nxt;
      last_rx_id_r <= last_rx_id_nxt;
      tx_id_r      <= tx_id_nxt;
    end
  end

  // Cleared on every idle byte before any data lands, so no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      payload_r <= payload_nxt;
    end
  end

endmodule

// ===== sv/umrf_queue.sv =====
`timescale 1ns / 1ps
// Short entry queue between the deframer and the result serializer.
// Depends on umrf_pkg.
module umrf_queue #(
  parameter int DEPTH = umrf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_stall,
  input  umrf_pkg::entry_t push_entry,
  output logic             pop_valid,
  input  logic             pop_stall,
  output umrf_pkg::entry_t pop_entry
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  umrf_pkg::entry_t slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             full;
  logic             push;
  logic             pop;

  assign full       = (count_r == CW'(DEPTH));
  assign push_stall = full;
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && !full;
  assign pop        = pop_valid && !pop_stall;
  assign pop_entry  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count past depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == CW'($past(count_r) + CW'(1)))
    else $error("queue count did not follow a lone push");
`endif

endmodule

// ===== sv/umrf_back.sv =====
`timescale 1ns / 1ps
// Back end: drains queue entries into the registered result port. A status
// entry gives one result; a reply entry is framed into nine transmit bytes.
// Depends on umrf_pkg.
module umrf_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_stall,
  input  umrf_pkg::entry_t q_entry,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_kind,
  output logic [2:0]       out_status,
  output logic             out_seq_gap,
  output logic [31:0]      out_mem_addr,
  output logic [31:0]      out_write_data,
  output logic [7:0]       out_byte_mask,
  output logic [7:0]       out_tx_byte,
  output logic             out_last
);

  localparam int          IW        = umrf_pkg::ID_W;
  localparam logic [3:0]  BEAT_LAST = 4'd8;
  localparam logic [IW-1:0] REPLY_LEN = IW'(4);

  logic            out_valid_r;
  logic            out_kind_r;
  logic [2:0]      out_status_r;
  logic            out_seq_gap_r;
  logic [31:0]     out_mem_addr_r;
  logic [31:0]     out_write_data_r;
  logic [7:0]      out_byte_mask_r;
  logic [7:0]      out_tx_byte_r;
  logic            out_last_r;
  logic            busy_r;
  logic [3:0]      beat_r;
  logic [31:0]     word_r;
  logic [IW-1:0]   id_r;
  logic            load_ok;

  function automatic logic [7:0] frame_byte(input logic [3:0] beat,
                                            input logic [IW-1:0] fid,
                                            input logic [31:0] word);
    logic [7:0] b;
    case (beat)
      4'd0:    b = {umrf_pkg::TAG_HEAD, fid};
      4'd1:    b = {umrf_pkg::TAG_CHANNEL, {IW{1'b0}}};
      4'd2:    b = {umrf_pkg::TAG_LENGTH, REPLY_LEN};
      4'd3:    b = {1'b0, word[6:0]};
      4'd4:    b = {1'b0, word[13:7]};
      4'd5:    b = {1'b0, word[20:14]};
      4'd6:    b = {1'b0, word[27:21]};
      4'd7:    b = {4'b0000, word[31:28]};
      4'd8:    b = {umrf_pkg::TAG_END, fid};
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  assign load_ok = !out_valid_r || !out_stall;
  assign q_stall = busy_r || !load_ok;

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_status     = out_status_r;
  assign out_seq_gap    = out_seq_gap_r;
  assign out_mem_addr   = out_mem_addr_r;
  assign out_write_data = out_write_data_r;
  assign out_byte_mask  = out_byte_mask_r;
  assign out_tx_byte    = out_tx_byte_r;
  assign out_last       = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      busy_r      <= 1'b0;
      beat_r      <= '0;
    end else if (load_ok) begin
      if (busy_r) begin
        out_valid_r   <= 1'b1;
        out_tx_byte_r <= frame_byte(beat_r, id_r, word_r);
        out_last_r    <= (beat_r == BEAT_LAST);
        beat_r        <= beat_r + 4'd1;
        if (beat_r == BEAT_LAST) begin
          busy_r <= 1'b0;
        end
      end else if (q_valid) begin
        out_valid_r      <= 1'b1;
        out_kind_r       <= q_entry.kind;
        out_last_r       <= 1'b0;
        if (q_entry.kind == umrf_pkg::KIND_RX) begin
          out_status_r     <= q_entry.status;
          out_seq_gap_r    <= q_entry.seq_gap;
          out_mem_addr_r   <= q_entry.mem_addr;
          out_write_data_r <= q_entry.write_data;
          out_byte_mask_r  <= q_entry.byte_mask;
          out_tx_byte_r    <= 8'd0;
        end else begin
          // Head byte goes out now, the other eight follow from word_r and id_r.
          out_status_r     <= umrf_pkg::ST_BUSY;
          out_seq_gap_r    <= 1'b0;
          out_mem_addr_r   <= '0;
          out_write_data_r <= '0;
          out_byte_mask_r  <= '0;
          out_tx_byte_r    <= frame_byte(4'd0, q_entry.tx_id, q_entry.reply_word);
          word_r           <= q_entry.reply_word;
          id_r             <= q_entry.tx_id;
          busy_r           <= 1'b1;
          beat_r           <= 4'd1;
        end
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_busy_holds_valid: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> out_valid_r)
    else $error("frame in progress without a result on the port");

  a_beat_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (beat_r != 4'd0 && beat_r <= BEAT_LAST))
    else $error("transmit beat out of range");

  a_last_is_tx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_kind_r == umrf_pkg::KIND_TX && !busy_r))
    else $error("last marker on a non-final or receive result");
`endif

endmodule

// ===== sv/uart_memory_request_framer_top.sv =====
`timescale 1ns / 1ps
// Top level of the memory request framer: deframer front end, entry queue
// and result serializer. Depends on umrf_pkg, umrf_front, umrf_queue, umrf_back.

// A received link byte (cmd 0) is taken every cycle unless the queue is full
// (in_stall) and yields one status result; a reply word (cmd 1) is taken as
// one item and yields nine transmit byte results, the last one flagged.
// A result is registered in the queue, then in the output register.
// Sustained input rate is one item per cycle for link bytes while the queue
// has room; reply frames are paced by the single-byte output port, and the queue
// of QUEUE_DEPTH entries lets link bytes keep flowing while a reply frame
// drains. Payload bits past PAYLOAD_STORE_BITS are dropped.
module uart_memory_request_framer_top #(
  parameter int PAYLOAD_STORE_BITS = umrf_pkg::PAYLOAD_STORE_BITS_DEF,
  parameter int QUEUE_DEPTH        = umrf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_rx_byte,
  input  logic [31:0] in_reply_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [2:0]  out_status,
  output logic        out_seq_gap,
  output logic [31:0] out_mem_addr,
  output logic [31:0] out_write_data,
  output logic [7:0]  out_byte_mask,
  output logic [7:0]  out_tx_byte,
  output logic        out_last
);

  logic             push_valid;
  logic             push_stall;
  umrf_pkg::entry_t push_entry;
  logic             pop_valid;
  logic             pop_stall;
  umrf_pkg::entry_t pop_entry;

  umrf_front #(
    .PAYLOAD_STORE_BITS(PAYLOAD_STORE_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_rx_byte   (in_rx_byte),
    .in_reply_word(in_reply_word),
    .push_valid   (push_valid),
    .push_stall   (push_stall),
    .push_entry   (push_entry)
  );

  umrf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_stall(push_stall),
    .push_entry(push_entry),
    .pop_valid (pop_valid),
    .pop_stall (pop_stall),
    .pop_entry (pop_entry)
  );

  umrf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (pop_valid),
    .q_stall       (pop_stall),
    .q_entry       (pop_entry),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_status    (out_status),
    .out_seq_gap   (out_seq_gap),
    .out_mem_addr  (out_mem_addr),
    .out_write_data(out_write_data),
    .out_byte_mask (out_byte_mask),
    .out_tx_byte   (out_tx_byte),
    .out_last      (out_last)
  );

endmodule

// ===== verif/uart_memory_request_framer_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for uart_memory_request_framer_top: directed link bytes, then random
// frames with reply words mixed in, scored against an in-bench deframer/framer model.
// Depends on umrf_pkg and the framer RTL.
module uart_memory_request_framer_top_test;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 141;

  typedef enum logic [2:0] {RX_IDLE, RX_CHANNEL, RX_LENGTH, RX_DATA, RX_END} rx_phase_t;
  typedef enum {FR_READ, FR_WRITE, FR_SHORT, FR_LONG, FR_BROKEN, FR_NOISE} frame_t;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  rx_byte;
    logic [31:0] reply_word;
    logic        typed;
    logic [2:0]  exp_status;
    logic        exp_gap;
  } link_item_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic        seq_gap;
    logic [31:0] mem_addr;
    logic [31:0] write_data;
    logic [7:0]  byte_mask;
    logic [7:0]  tx_byte;
    logic        last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_cmd;
  logic [7:0]  in_rx_byte;
  logic [31:0] in_reply_word;
  logic        out_valid;
  logic        out_stall;
  logic        out_kind;
  logic [2:0]  out_status;
  logic        out_seq_gap;
  logic [31:0] out_mem_addr;
  logic [31:0] out_write_data;
  logic [7:0]  out_byte_mask;
  logic [7:0]  out_tx_byte;
  logic        out_last;

  // row-side info that travels with the payload on the input channel
  logic        row_typed;
  logic [2:0]  row_status;
  logic        row_gap;

  // framer model state
  rx_phase_t   dfr_phase;
  logic [71:0] dfr_payload;
  int unsigned dfr_bits;
  int unsigned dfr_target;
  logic [4:0]  dfr_last_id;
  logic [4:0]  tx_frame_id;

  result_t     pending_results[$];
  link_item_t  link_items[$];
  logic [4:0]  gen_rx_id;
  int          random_items;
  int          results_seen = 0;
  int          mismatch_count = 0;
  int          quiet_cycles = 0;

  // Directed rows; after reset the next expected frame id is 1.
  link_item_t directed_rows [0:28] = '{
    {1'b0, 8'h00, 32'hFFFF_FFFF, 1'b1, umrf_pkg::ST_CORRUPT,     1'b0},  // idle, wrong tag
    {1'b0, 8'hFF, 32'h0000_0000, 1'b1, umrf_pkg::ST_CORRUPT,     1'b0},
    {1'b0, 8'h81, 32'h0000_0000, 1'b1, umrf_pkg::ST_BUSY,        1'b0},  // head, id 1
    {1'b0, 8'h00, 32'h0000_0000, 1'b1, umrf_pkg::ST_CORRUPT,     1'b0},  // bad channel tag
    {1'b0, 8'h9F, 32'h0000_0000, 1'b1, umrf_pkg::ST_BUSY,        1'b1},  // head, id out of order
    {1'b0, 8'hA0, 32'h0000_0000, 1'b1, umrf_pkg::ST_BUSY,        1'b0},
    {1'b0, 8'hA0, 32'h0000_0000, 1'b1, umrf_pkg::ST_CORRUPT,     1'b0},  // bad length tag
    {1'b0, 8'h81, 32'h0000_0000, 1'b1, umrf_pkg::ST_BUSY,        1'b0},
    {1'b0, 8'hBF, 32'h0000_0000, 1'b1, umrf_pkg::ST_BUSY,        1'b0},
    {1'b0, 8'hC0, 32'h0000_0000, 1'b1, umrf_pkg::ST_BUSY,        1'b0},  // zero length
    {1'b0, 8'h80, 32'h0000_0000, 1'b1, umrf_pkg::ST_CORRUPT,     1'b0},  // data with top bit set
    {1'b0, 8'h81, 32'h0000_0000, 1'b1, umrf_pkg::ST_BUSY,        1'b0},
    {1'b0, 8'hA0, 32'h0000_0000, 1'b1, umrf_pkg::ST_BUSY,        1'b0},
    {1'b0, 8'hC0, 32'h0000_0000, 1'b1, umrf_pkg::ST_BUSY,        1'b0},
    {1'b0, 8'h00, 32'h0000_0000, 1'b1, umrf_pkg::ST_BUSY,        1'b0},
    {1'b0, 8'h00, 32'h0000_0000, 1'b1, umrf_pkg::ST_CORRUPT,     1'b0},  // bad end tag
    {1'b0, 8'h81, 32'h0000_0000, 1'b1, umrf_pkg::ST_BUSY,        1'b0},
    {1'b0, 8'hA0, 32'h0000_0000, 1'b1, umrf_pkg::ST_BUSY,        1'b0},
    {1'b0, 8'hC0, 32'h0000_0000, 1'b1, umrf_pkg::ST_BUSY,        1'b0},
    {1'b0, 8'h7F, 32'h0000_0000, 1'b1, umrf_pkg::ST_BUSY,        1'b0},
    {1'b0, 8'hE2, 32'h0000_0000, 1'b1, umrf_pkg::ST_ID_MISMATCH, 1'b0},
    {1'b1, 8'hFF, 32'hFFFF_FFFF, 1'b0, umrf_pkg::ST_BUSY,        1'b0},  // replies at the extremes
    {1'b1, 8'h00, 32'h0000_0000, 1'b0, umrf_pkg::ST_BUSY,        1'b0},
    {1'b0, 8'h81, 32'h0000_0000, 1'b1, umrf_pkg::ST_BUSY,        1'b0},
    {1'b0, 8'hA0, 32'h0000_0000, 1'b1, umrf_pkg::ST_BUSY,        1'b0},
    {1'b0, 8'hC0, 32'h0000_0000, 1'b1, umrf_pkg::ST_BUSY,        1'b0},
    {1'b1, 8'h5A, 32'h1234_5678, 1'b0, umrf_pkg::ST_BUSY,        1'b0},  // reply in mid frame
    {1'b0, 8'h7F, 32'h0000_0000, 1'b1, umrf_pkg::ST_BUSY,        1'b0},
    {1'b0, 8'hE1, 32'h0000_0000, 1'b1, umrf_pkg::ST_IGNORED,     1'b0}
  };

  uart_memory_request_framer_top DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_rx_byte    (in_rx_byte),
    .in_reply_word (in_reply_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_status    (out_status),
    .out_seq_gap   (out_seq_gap),
    .out_mem_addr  (out_mem_addr),
    .out_write_data(out_write_data),
    .out_byte_mask (out_byte_mask),
    .out_tx_byte   (out_tx_byte),
    .out_last      (out_last)
  );

  always #1 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic predict_framer(input logic cmd, input logic [7:0] b, input logic [31:0] w,
                                input logic typed, input logic [2:0] t_status,
                                input logic t_gap);
    result_t     r;
    logic [2:0]  tag;
    logic [4:0]  id;
    logic [4:0]  next_id;
    logic [31:0] chunk;
    int          i;
    tag = b[7:5];
    id = b[4:0];
    next_id = dfr_last_id + 5'd1;
    if (cmd) begin
      for (i = 0; i < 9; i++) begin
        r = '0;
        r.kind = umrf_pkg::KIND_TX;
        r.last = (i == 8);
        chunk = w >> (7 * (i - 3));
        if (i == 0) r.tx_byte = {umrf_pkg::TAG_HEAD, tx_frame_id};
        else if (i == 1) r.tx_byte = {umrf_pkg::TAG_CHANNEL, 5'd0};
        else if (i == 2) r.tx_byte = {umrf_pkg::TAG_LENGTH, 5'd4};
        else if (i == 8) r.tx_byte = {umrf_pkg::TAG_END, tx_frame_id};
        else r.tx_byte = {1'b0, chunk[6:0]};
        pending_results = {pending_results, r};
      end
      tx_frame_id = tx_frame_id + 5'd1;
      return;
    end
    r = '0;
    r.kind = umrf_pkg::KIND_RX;
    r.status = umrf_pkg::ST_BUSY;
    case (dfr_phase)
      RX_IDLE: begin
        dfr_payload = '0;
        if (tag == umrf_pkg::TAG_HEAD) begin
          dfr_bits = 0;
          dfr_target = 0;
          dfr_phase = RX_CHANNEL;
          r.seq_gap = (id != next_id);
        end else begin
          r.status = umrf_pkg::ST_CORRUPT;
        end
      end
      RX_CHANNEL: begin
        if (tag == umrf_pkg::TAG_CHANNEL) dfr_phase = RX_LENGTH;
        else begin
          dfr_phase = RX_IDLE;
          r.status = umrf_pkg::ST_CORRUPT;
        end
      end
      RX_LENGTH: begin
        if (tag == umrf_pkg::TAG_LENGTH) begin
          dfr_target = id * 8;
          dfr_phase = RX_DATA;
        end else begin
          dfr_phase = RX_IDLE;
          r.status = umrf_pkg::ST_CORRUPT;
        end
      end
      RX_DATA: begin
        if (!b[7]) begin
          // up to seven bits per byte, LSB first; bits past the store are dropped
          i = 0;
          while (i < 7 && dfr_bits < dfr_target) begin
            if (dfr_bits < umrf_pkg::PAYLOAD_STORE_BITS_DEF) dfr_payload[dfr_bits] = b[i];
            i++;
            dfr_bits++;
          end
          if (dfr_bits == dfr_target) dfr_phase = RX_END;
        end else begin
          dfr_phase = RX_IDLE;
          r.status = umrf_pkg::ST_CORRUPT;
        end
      end
      default: begin
        dfr_phase = RX_IDLE;
        if (tag != umrf_pkg::TAG_END) r.status = umrf_pkg::ST_CORRUPT;
        else if (id != next_id) r.status = umrf_pkg::ST_ID_MISMATCH;
        else begin
          dfr_last_id = id;
          if (dfr_bits == 40 && dfr_payload[39:32] == 8'h00) begin
            r.status = umrf_pkg::ST_READ;
            r.mem_addr = dfr_payload[31:0];
          end else if (dfr_bits == 72) begin
            r.status = umrf_pkg::ST_WRITE;
            r.mem_addr = dfr_payload[63:32];
            r.write_data = dfr_payload[31:0];
            r.byte_mask = dfr_payload[71:64];
          end else begin
            r.status = umrf_pkg::ST_IGNORED;
          end
        end
      end
    endcase
    if (typed) begin
      r = '0;
      r.kind = umrf_pkg::KIND_RX;
      r.status = t_status;
      r.seq_gap = t_gap;
    end
    pending_results = {pending_results, r};
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_result();
    result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result with nothing pending, kind %0d status %0d tx_byte %h",
               $time, out_kind, out_status, out_tx_byte);
      mismatch_count++;
    end else begin
      want = pending_results.pop_front();
      check_field("kind", 32'(want.kind), 32'(out_kind));
      check_field("status", 32'(want.status), 32'(out_status));
      check_field("seq_gap", 32'(want.seq_gap), 32'(out_seq_gap));
      check_field("mem_addr", want.mem_addr, out_mem_addr);
      check_field("write_data", want.write_data, out_write_data);
      check_field("byte_mask", 32'(want.byte_mask), 32'(out_byte_mask));
      check_field("tx_byte", 32'(want.tx_byte), 32'(out_tx_byte));
      check_field("last", 32'(want.last), 32'(out_last));
    end
  endtask

  task automatic push_item(input logic cmd, input logic [7:0] b, input logic [31:0] w);
    link_item_t it;
    it = '0;
    it.cmd = cmd;
    it.rx_byte = b;
    it.reply_word = w;
    link_items = {link_items, it};
    random_items++;
  endtask

  // a reply word now and then lands between link bytes
  task automatic push_link(input logic [7:0] b);
    if ($urandom_range(0, 14) == 0) push_item(1'b1, 8'($urandom), $urandom);
    push_item(1'b0, b, $urandom);
  endtask

  task automatic gen_frame(input frame_t kind);
    logic [255:0] bits;
    logic [7:0]   b;
    logic [4:0]   hid;
    int           len;
    int           nchunks;
    int           brk;
    int           k;
    if (kind == FR_NOISE) begin
      repeat ($urandom_range(1, 3)) begin
        b = 8'($urandom);
        if (b[7:5] == umrf_pkg::TAG_HEAD) b[7] = 1'b0;  // keep noise from opening a frame
        push_link(b);
      end
      return;
    end
    case (kind)
      FR_READ:  len = 5;
      FR_WRITE: len = 9;
      FR_LONG:  len = $urandom_range(10, 31);
      default:  len = $urandom_range(0, 12);
    endcase
    for (k = 0; k < 8; k++) bits[32*k +: 32] = $urandom;
    if (kind == FR_READ && $urandom_range(0, 7) != 0) bits[39:32] = '0;
    nchunks = (len == 0) ? 1 : (len * 8 + 6) / 7;
    // break point: 1 channel, 2 length, 3.. data, nchunks+3 end
    brk = (kind == FR_BROKEN) ? $urandom_range(1, nchunks + 3) : 0;
    hid = ($urandom_range(0, 7) == 0) ? 5'($urandom) : gen_rx_id + 5'd1;
    push_link({umrf_pkg::TAG_HEAD, hid});
    b = 8'($urandom);
    if (brk == 1) begin
      if (b[7:5] == umrf_pkg::TAG_CHANNEL) b[7] = 1'b0;
      push_link(b);
      return;
    end
    push_link({umrf_pkg::TAG_CHANNEL, b[4:0]});
    b = 8'($urandom);
    if (brk == 2) begin
      if (b[7:5] == umrf_pkg::TAG_LENGTH) b[7] = 1'b0;
      push_link(b);
      return;
    end
    push_link({umrf_pkg::TAG_LENGTH, 5'(len)});
    for (k = 0; k < nchunks; k++) begin
      if (brk == k + 3) begin
        b = 8'($urandom);
        b[7] = 1'b1;
        push_link(b);
        return;
      end
      push_link({1'b0, bits[7*k +: 7]});
    end
    if (brk == nchunks + 3) begin
      b = 8'($urandom);
      if (b[0]) b = {umrf_pkg::TAG_END, gen_rx_id + 5'd2};
      else if (b[7:5] == umrf_pkg::TAG_END) b[6] = 1'b0;
      push_link(b);
      return;
    end
    push_link({umrf_pkg::TAG_END, gen_rx_id + 5'd1});
    gen_rx_id = gen_rx_id + 5'd1;
  endtask

  function automatic frame_t pick_kind(input int frame_no);
    int r;
    if (frame_no == 0) return FR_WRITE;
    if (frame_no == 1) return FR_READ;
    if (frame_no == 2) return FR_LONG;
    r = $urandom_range(0, 99);
    if (r < 25) return FR_READ;
    if (r < 50) return FR_WRITE;
    if (r < 65) return FR_SHORT;
    if (r < 68) return FR_LONG;
    if (r < 85) return FR_BROKEN;
    return FR_NOISE;
  endfunction

  // scoreboard and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        check_result();
        results_seen++;
      end
      if (in_valid && !in_stall)
        predict_framer(in_cmd, in_rx_byte, in_reply_word, row_typed, row_status, row_gap);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) quiet_cycles = 0;
      else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("uart_memory_request_framer_top test failed");
          $finish;
        end
      end
    end
  end

  // result side: random stalls, quiet stretches, one long hold-off
  initial begin
    int stall_left;
    int n;
    bit recv_quiet;
    bit hold_done;
    out_stall = 1'b0;
    stall_left = 0;
    recv_quiet = 1'b0;
    hold_done = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= 100) begin
        hold_done = 1'b1;
        stall_left = 150;
      end
      if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        n = recv_quiet ? 0 : pick_gap();
        if (n == 0) out_stall <= 1'b0;
        else begin
          out_stall <= 1'b1;
          stall_left = n - 1;
        end
      end
    end
  end

  // input side
  initial begin
    link_item_t it;
    int         idx;
    int         gap;
    int         dir_count;
    int         frame_no;
    bit         send_burst;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = 1'b0;
    in_rx_byte = '0;
    in_reply_word = '0;
    row_typed = 1'b0;
    row_status = umrf_pkg::ST_BUSY;
    row_gap = 1'b0;
    dfr_phase = RX_IDLE;
    dfr_payload = '0;
    dfr_bits = 0;
    dfr_target = 0;
    dfr_last_id = '0;
    tx_frame_id = '0;
    send_burst = 1'b0;
    foreach (directed_rows[i]) link_items = {link_items, directed_rows[i]};
    dir_count = link_items.size();
    gen_rx_id = 5'd1;  // the directed rows end with frame id 1 taken
    random_items = 0;
    frame_no = 0;
    while (random_items < RANDOM_ITEMS) begin
      gen_frame(pick_kind(frame_no));
      frame_no++;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (idx = 0; idx < link_items.size(); idx++) begin
      if (idx == dir_count || idx == dir_count + 90) begin
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
      gap = send_burst ? 0 : pick_gap();
      it = link_items[idx];
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid <= 1'b1;
      in_cmd <= it.cmd;
      in_rx_byte <= it.rx_byte;
      in_reply_word <= it.reply_word;
      row_typed <= it.typed;
      row_status <= it.exp_status;
      row_gap <= it.exp_gap;
      do @(posedge clk); while (in_stall);
      @(negedge clk);
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatch_count == 0) $display("uart_memory_request_framer_top test passed");
    else $display("uart_memory_request_framer_top test failed");
    $finish;
  end

endmodule
